// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lmce_pkg.sv =====
// ----------------------------------------------------------------------------
// lmce_pkg
// Types and constants shared by the list mode character escaper.
// ----------------------------------------------------------------------------
package lmce_pkg;

	localparam int COL_W        = 7;
	localparam int LINE_COLUMNS = 72;
	localparam int QUEUE_DEPTH  = 4;
	localparam int PTR_W        = $clog2(QUEUE_DEPTH);
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int STEP_W       = 3;

	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_BS    = 8'h08;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_BSL   = 8'h5C;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_GT    = 8'h3E;
	localparam logic [7:0] CHAR_LT    = 8'h3C;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_ARROW,
		KIND_OCTAL
	} kind_t;

	typedef struct packed {
		logic       wrap;
		kind_t      kind;
		logic [7:0] ch;
	} req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== design/lmce_front.sv =====
// ----------------------------------------------------------------------------
// lmce_front
// Accepts requests, tracks the column and classifies each character.
// ----------------------------------------------------------------------------
module lmce_front #(
	parameter int LINE_COLUMNS = lmce_pkg::LINE_COLUMNS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          character,
	input  logic                line_start,
	input  lmce_pkg::q_status_t q_status,
	output logic                push,
	output lmce_pkg::req_t      push_req
);

	localparam logic [lmce_pkg::COL_W-1:0] LIMIT = lmce_pkg::COL_W'(LINE_COLUMNS);
	localparam logic [lmce_pkg::COL_W-1:0] ONE   = lmce_pkg::COL_W'(1);
	localparam logic [lmce_pkg::COL_W-1:0] TWO   = lmce_pkg::COL_W'(2);

	logic                        list_mode_q;
	logic [lmce_pkg::COL_W-1:0]  column_q;
	logic [lmce_pkg::COL_W-1:0]  col_base;
	logic [lmce_pkg::COL_W-1:0]  col_inc;
	logic [lmce_pkg::COL_W-1:0]  col_next;
	logic                        wrap;
	logic                        is_arrow;
	logic                        is_ctrl;

	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	always_comb begin
		col_base = line_start ? '0 : column_q;
		col_inc  = col_base + ONE;
		wrap     = list_mode_q && (col_inc >= LIMIT);
		is_arrow = (character == lmce_pkg::CHAR_TAB) || (character == lmce_pkg::CHAR_BS);
		is_ctrl  = (character < lmce_pkg::CHAR_SPACE) && (character != lmce_pkg::CHAR_NL);
		push_req.wrap = wrap;
		push_req.ch   = character;
		if (!list_mode_q) begin
			col_next      = col_base;
			push_req.kind = lmce_pkg::KIND_PLAIN;
		end else if (is_arrow) begin
			col_next      = wrap ? '0 : col_inc;
			push_req.kind = lmce_pkg::KIND_ARROW;
		end else if (is_ctrl) begin
			col_next      = (wrap ? '0 : col_inc) + TWO;
			push_req.kind = lmce_pkg::KIND_OCTAL;
		end else begin
			col_next      = wrap ? '0 : col_inc;
			push_req.kind = lmce_pkg::KIND_PLAIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_mode_q <= 1'b0;
			column_q    <= '0;
		end else begin
			if (cfg_we) begin
				list_mode_q <= cfg_wdata;
			end
			if (push) begin
				column_q <= col_next;
			end
		end
	end

endmodule

// ===== design/lmce_queue.sv =====
// ----------------------------------------------------------------------------
// lmce_queue
// Short request queue between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmce_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lmce_pkg::req_t      push_req,
	input  logic                pop,
	output lmce_pkg::req_t      head_req,
	output lmce_pkg::q_status_t status
);

	localparam logic [lmce_pkg::CNT_W-1:0] DEPTH_CNT = lmce_pkg::CNT_W'(lmce_pkg::QUEUE_DEPTH);

	lmce_pkg::req_t              slots_q [lmce_pkg::QUEUE_DEPTH];
	logic [lmce_pkg::PTR_W-1:0]  wr_ptr_q;
	logic [lmce_pkg::PTR_W-1:0]  rd_ptr_q;
	logic [lmce_pkg::CNT_W-1:0]  count_q;

	assign head_req     = slots_q[rd_ptr_q];
	assign status.full  = (count_q == DEPTH_CNT);
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + lmce_pkg::PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lmce_pkg::PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + lmce_pkg::CNT_W'(1);
				2'b01:   count_q <= count_q - lmce_pkg::CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_IMPLY(a_no_overflow, push, !status.full || pop, "push into full queue")
	`ASSERT_IMPLY(a_no_underflow, pop, !status.empty, "pop from empty queue")
	`ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= DEPTH_CNT, "queue count out of range")

endmodule

// ===== design/lmce_back.sv =====
// ----------------------------------------------------------------------------
// lmce_back
// Expands each queued request into its terminal bytes, one per cycle unless out_stall holds the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmce_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lmce_pkg::req_t      head_req,
	input  lmce_pkg::q_status_t q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                last
);

	logic [lmce_pkg::STEP_W-1:0] step_q;
	logic [lmce_pkg::STEP_W-1:0] body;
	logic [lmce_pkg::STEP_W-1:0] last_step;
	logic [7:0]                  byte_d;
	logic                        last_d;
	logic                        load;
	logic                        out_valid_q;
	logic [7:0]                  out_byte_q;
	logic                        last_q;

	assign load      = (!out_valid_q || !out_stall) && !q_status.empty;
	assign pop       = load && last_d;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	always_comb begin
		body      = head_req.wrap ? step_q - lmce_pkg::STEP_W'(2) : step_q;
		last_step = (head_req.wrap ? lmce_pkg::STEP_W'(2) : '0)
			+ ((head_req.kind == lmce_pkg::KIND_PLAIN) ? '0 : lmce_pkg::STEP_W'(2));
		last_d    = (step_q == last_step);
		if (head_req.wrap && (step_q < lmce_pkg::STEP_W'(2))) begin
			byte_d = step_q[0] ? lmce_pkg::CHAR_NL : lmce_pkg::CHAR_BSL;
		end else begin
			case (head_req.kind)
				lmce_pkg::KIND_ARROW: begin
					case (body[1:0])
						2'd0:    byte_d = lmce_pkg::CHAR_DASH;
						2'd1:    byte_d = lmce_pkg::CHAR_BS;
						default: byte_d = (head_req.ch == lmce_pkg::CHAR_TAB)
							? lmce_pkg::CHAR_GT : lmce_pkg::CHAR_LT;
					endcase
				end
				lmce_pkg::KIND_OCTAL: begin
					case (body[1:0])
						2'd0:    byte_d = lmce_pkg::CHAR_BSL;
						2'd1:    byte_d = lmce_pkg::CHAR_ZERO | {6'd0, head_req.ch[4:3]};
						default: byte_d = lmce_pkg::CHAR_ZERO | {5'd0, head_req.ch[2:0]};
					endcase
				end
				default: byte_d = head_req.ch;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_d;
			last_q     <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= last_d ? '0 : step_q + lmce_pkg::STEP_W'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_IMPLY(a_step_range, 1'b1, step_q <= lmce_pkg::STEP_W'(4), "byte step out of range")
	`ASSERT_NEXT(a_hold_step, out_valid_q && out_stall, $stable(step_q), "step moved while stalled")
	`ASSERT_NEXT(a_pop_rewinds, pop, step_q == '0, "step not rewound after last byte")

endmodule

// ===== design/list_mode_char_escaper_top.sv =====
// ----------------------------------------------------------------------------
// list_mode_char_escaper_top
// Terminal escaper for list mode printing with column wrap.
// ----------------------------------------------------------------------------
// Each request carries one character; the block returns its terminal bytes,
// one byte per cycle unless out_stall is set, with last set on the final byte.
// With list_mode clear a character yields one byte. With list_mode set, tab
// and backspace yield three bytes, other control codes except newline yield a
// backslash and two octal digits, and a line wrap at LINE_COLUMNS adds a
// backslash and newline in front, so one request yields 1 to 5 bytes. The front
// accepts a request every cycle while its four-entry queue has room; sustained
// throughput is set by the single output byte register, one byte per cycle
// unless stalled. cfg_we/cfg_wdata write list_mode, effective on the next request.
module list_mode_char_escaper_top #(
	parameter int LINE_COLUMNS = lmce_pkg::LINE_COLUMNS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] character,
	input  logic       line_start,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last
);

	logic                push;
	logic                pop;
	lmce_pkg::req_t      push_req;
	lmce_pkg::req_t      head_req;
	lmce_pkg::q_status_t q_status;

	lmce_front #(
		.LINE_COLUMNS (LINE_COLUMNS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.character  (character),
		.line_start (line_start),
		.q_status   (q_status),
		.push       (push),
		.push_req   (push_req)
	);

	lmce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head_req (head_req),
		.status   (q_status)
	);

	lmce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_req  (head_req),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

// ===== tb/list_mode_char_escaper_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_mode_char_escaper_checker
// Watches the request, result and register ports of the escaper and keeps its
// own model of the list mode flag and the column counter. Every accepted
// request adds its expected terminal bytes to an in-order store; every
// accepted output byte is compared against the oldest one, byte and last flag.
// ----------------------------------------------------------------------------
module list_mode_char_escaper_checker #(
	parameter int WRAP_COLUMNS = lmce_pkg::LINE_COLUMNS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] character,
	input  logic       line_start,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       last,
	output int         errors,
	output int         pending,
	output int         requests_seen,
	output int         bytes_seen,
	output int         wraps_seen
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} term_byte_t;

	term_byte_t                 term_bytes_q[$];
	logic                       list_mode;
	logic [lmce_pkg::COL_W-1:0] column;
	int                         err_cnt;
	int                         req_cnt;
	int                         byte_cnt;
	int                         wrap_cnt;

	task automatic escape_char(input logic [7:0] ch, input logic ls);
		logic [7:0] seq[$];
		if (ls)
			column = '0;
		if (list_mode) begin
			column = column + 1'b1;
			if (int'(column) >= WRAP_COLUMNS) begin
				column = '0;
				seq.push_back(lmce_pkg::CHAR_BSL);
				seq.push_back(lmce_pkg::CHAR_NL);
				wrap_cnt++;
			end
			if (ch == lmce_pkg::CHAR_TAB || ch == lmce_pkg::CHAR_BS) begin
				seq.push_back(lmce_pkg::CHAR_DASH);
				seq.push_back(lmce_pkg::CHAR_BS);
				seq.push_back(ch == lmce_pkg::CHAR_TAB ? lmce_pkg::CHAR_GT : lmce_pkg::CHAR_LT);
			end else if (ch < lmce_pkg::CHAR_SPACE && ch != lmce_pkg::CHAR_NL) begin
				seq.push_back(lmce_pkg::CHAR_BSL);
				seq.push_back(lmce_pkg::CHAR_ZERO + (ch >> 3));
				seq.push_back(lmce_pkg::CHAR_ZERO + (ch & 8'h07));
				column = column + 2'd2;
			end else begin
				seq.push_back(ch);
			end
		end else begin
			seq.push_back(ch);
		end
		foreach (seq[i])
			term_bytes_q.push_back('{data: seq[i], last: (i == seq.size() - 1)});
	endtask

	always @(posedge clk) begin
		term_byte_t want;
		if (!arst_n) begin
			term_bytes_q.delete();
			list_mode = 1'b0;
			column    = '0;
			err_cnt   = 0;
			req_cnt   = 0;
			byte_cnt  = 0;
			wrap_cnt  = 0;
		end else begin
			if (cfg_we)
				list_mode = cfg_wdata;
			if (in_valid && !in_stall) begin
				req_cnt++;
				escape_char(character, line_start);
			end
			if (out_valid && !out_stall) begin
				byte_cnt++;
				if (term_bytes_q.size() == 0) begin
					$error("out_byte: no byte expected, got %02h (last %0b)", out_byte, last);
					err_cnt++;
				end else begin
					want = term_bytes_q.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, out_byte);
						err_cnt++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						err_cnt++;
					end
				end
			end
		end
		errors        <= err_cnt;
		pending       <= term_bytes_q.size();
		requests_seen <= req_cnt;
		bytes_seen    <= byte_cnt;
		wraps_seen    <= wrap_cnt;
	end

endmodule

// ===== tb/list_mode_char_escaper_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_mode_char_escaper_top_tb
// Drives characters into the escaper under several sender idle and receiver
// stall mixes, with list mode switched off and on between phases. A directed
// set covers byte extremes and every escape form, then random text lines
// exercise column wrap and line starts. Checking is done by the checker.
// ----------------------------------------------------------------------------
module list_mode_char_escaper_top_tb;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_REQS  = 85;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       cfg_we     = 1'b0;
	logic       cfg_wdata  = 1'b0;
	logic       in_valid   = 1'b0;
	logic [7:0] character  = '0;
	logic       line_start = 1'b0;
	logic       out_stall  = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       last;

	int errors;
	int pending;
	int requests_seen;
	int bytes_seen;
	int wraps_seen;
	int in_idle_pct   = 0;
	int out_stall_pct = 0;
	int quiet_cycles  = 0;
	int line_left     = 0;

	list_mode_char_escaper_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.character  (character),
		.line_start (line_start),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last       (last)
	);

	list_mode_char_escaper_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.character     (character),
		.line_start    (line_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.last          (last),
		.errors        (errors),
		.pending       (pending),
		.requests_seen (requests_seen),
		.bytes_seen    (bytes_seen),
		.wraps_seen    (wraps_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d bytes outstanding",
				QUIET_LIMIT, pending);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input logic [7:0] ch, input logic ls);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		character  <= ch;
		line_start <= ls;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// hold off until every expected byte has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_list_mode(input logic mode);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [7:0] random_char();
		int pick;
		pick = $urandom_range(99);
		if (pick < 65)
			return 8'($urandom_range(8'h7E, 8'h20));
		else if (pick < 72)
			return lmce_pkg::CHAR_TAB;
		else if (pick < 77)
			return lmce_pkg::CHAR_BS;
		else if (pick < 82)
			return lmce_pkg::CHAR_NL;
		else if (pick < 92)
			return 8'($urandom_range(8'h1F, 8'h00));
		else
			return 8'($urandom_range(8'hFF, 8'h7F));
	endfunction

	task automatic run_phase(input int idle_pct, input int stall_pct, input logic mode,
		input int count);
		logic ls;
		write_list_mode(mode);
		in_idle_pct   = idle_pct;
		out_stall_pct = stall_pct;
		repeat (count) begin
			ls = 1'b0;
			if (line_left == 0) begin
				line_left = $urandom_range(100, 1);
				ls = 1'b1;
			end else if ($urandom_range(99) < 3) begin
				ls = 1'b1;
			end
			line_left--;
			send_request(random_char(), ls);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(8'h00, 1'b1);
		send_request(8'hFF, 1'b0);
		send_request(lmce_pkg::CHAR_TAB, 1'b0);
		send_request(lmce_pkg::CHAR_BS, 1'b0);

		write_list_mode(1'b1);
		send_request(lmce_pkg::CHAR_TAB, 1'b1);
		send_request(lmce_pkg::CHAR_BS, 1'b0);
		send_request(lmce_pkg::CHAR_NL, 1'b0);
		send_request(8'h00, 1'b0);
		send_request(8'h07, 1'b0);
		send_request(8'h1B, 1'b0);
		send_request(8'h1F, 1'b0);
		send_request(lmce_pkg::CHAR_SPACE, 1'b0);
		send_request(8'h41, 1'b0);
		send_request(8'h7E, 1'b0);
		send_request(8'h7F, 1'b0);
		send_request(8'h80, 1'b0);
		send_request(8'hFF, 1'b1);

		run_phase(0, 0, 1'b1, PHASE_REQS);
		run_phase(60, 0, 1'b0, PHASE_REQS);
		run_phase(0, 60, 1'b1, PHASE_REQS);
		run_phase(29, 29, 1'b1, PHASE_REQS);

		wait_drained();
		repeat (16) @(posedge clk);

		$display("Escaped %0d characters into %0d terminal bytes, %0d line wraps,",
			requests_seen, bytes_seen, wraps_seen);
		$display("across list mode off and on with idle and stall mixes of 0/60/29 percent.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
